FILE: hdl/eudc_pkg.sv
// Shared constants, types and the arctangent table for the Euler/DCM attitude converter.
`timescale 1ns / 1ps
`default_nettype none

package eudc_pkg;

    // Stream widths
    localparam int IN_DW  = 104;  // 98 payload bits padded to whole bytes
    localparam int CMD_W  = 3;
    localparam int OUT_DW = 192;
    localparam int NROW   = 3;

    // CORDIC datapath
    localparam int CW    = 34;    // x / y width
    localparam int ZW    = 24;    // angle accumulator width, radians * 2^20
    localparam int ITER  = 20;
    localparam int IW    = 5;
    localparam int MW    = 23;    // multiplier operand width
    localparam int PW    = 2 * MW;
    localparam int AW    = 64;    // matrix term accumulator

    localparam logic signed [ZW-1:0] PI_Q20      = 24'sd3294199;
    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [CW-1:0] CORDIC_K30  = 34'sd652032874;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ROW   = 3'd0,
        CMD_COL   = 3'd1,
        CMD_ALL   = 3'd2,
        CMD_ROLL  = 3'd3,
        CMD_PITCH = 3'd4,
        CMD_YAW   = 3'd5
    } t_cmd;

    // Request into the CORDIC unit
    typedef struct packed {
        logic                 start;
        logic                 vect;   // 1: vectoring (atan2), 0: rotation (sin/cos)
        logic signed [15:0]   ang;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_cor_req;

    // Result from the CORDIC unit
    typedef struct packed {
        logic                 done;
        logic signed [MW-1:0] cos_v;
        logic signed [MW-1:0] sin_v;
        logic signed [ZW-1:0] z;
    } t_cor_rsp;

    // atan(2^-i) in radians * 2^20
    function automatic logic signed [ZW-1:0] atan_tab(input logic [IW-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/eudc_cordic.sv
// Iterative CORDIC: rotation mode for sin/cos, vectoring mode for atan2, one step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module eudc_cordic (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  eudc_pkg::t_cor_req  i_req,
    output eudc_pkg::t_cor_rsp  o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic                           r_vect;
    logic                           r_neg;
    logic                           r_zero;
    logic [eudc_pkg::IW-1:0]        r_i;
    logic signed [eudc_pkg::CW-1:0] r_x;
    logic signed [eudc_pkg::CW-1:0] r_y;
    logic signed [eudc_pkg::ZW-1:0] r_z;

    logic signed [eudc_pkg::CW-1:0] dx;
    logic signed [eudc_pkg::CW-1:0] dy;
    logic signed [eudc_pkg::ZW-1:0] at;
    logic                           dir;
    logic signed [eudc_pkg::ZW-1:0] z_rot;
    logic signed [eudc_pkg::CW-1:0] x_rnd;
    logic signed [eudc_pkg::CW-1:0] y_rnd;
    logic signed [eudc_pkg::MW-1:0] c_v;
    logic signed [eudc_pkg::MW-1:0] s_v;

    // shift and table for the current step
    assign dx  = r_y >>> r_i;
    assign dy  = r_x >>> r_i;
    assign at  = eudc_pkg::atan_tab(r_i);
    // dir: x -= dx, y += dy, z -= atan
    assign dir = r_vect ? !(r_y > 0) : (r_z >= 0);

    // input angle scaled to radians * 2^20
    assign z_rot = {{(eudc_pkg::ZW-16){i_req.ang[15]}}, i_req.ang} <<< 7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_vect <= i_req.vect;
                r_zero <= i_req.vect && (i_req.x == 0) && (i_req.y == 0);
                if (i_req.vect) begin
                    // fold left half plane onto the right
                    r_neg <= 1'b0;
                    if (i_req.x < 0) begin
                        r_x <= -i_req.x;
                        r_y <= -i_req.y;
                        r_z <= (i_req.y >= 0) ? eudc_pkg::PI_Q20 : -eudc_pkg::PI_Q20;
                    end else begin
                        r_x <= i_req.x;
                        r_y <= i_req.y;
                        r_z <= '0;
                    end
                end else begin
                    // fold angle into [-pi/2, pi/2], negate results later
                    r_x <= eudc_pkg::CORDIC_K30;
                    r_y <= '0;
                    if (z_rot > eudc_pkg::HALF_PI_Q20) begin
                        r_z   <= z_rot - eudc_pkg::PI_Q20;
                        r_neg <= 1'b1;
                    end else if (z_rot < -eudc_pkg::HALF_PI_Q20) begin
                        r_z   <= z_rot + eudc_pkg::PI_Q20;
                        r_neg <= 1'b1;
                    end else begin
                        r_z   <= z_rot;
                        r_neg <= 1'b0;
                    end
                end
            end else if (r_busy) begin
                if (dir) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == eudc_pkg::IW'(eudc_pkg::ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // round to 2^20 and undo the fold
    assign x_rnd = (r_x + 34'sd512) >>> 10;
    assign y_rnd = (r_y + 34'sd512) >>> 10;
    assign c_v   = r_neg ? -x_rnd[eudc_pkg::MW-1:0] : x_rnd[eudc_pkg::MW-1:0];
    assign s_v   = r_neg ? -y_rnd[eudc_pkg::MW-1:0] : y_rnd[eudc_pkg::MW-1:0];

    assign o_rsp.done  = r_done;
    assign o_rsp.cos_v = c_v;
    assign o_rsp.sin_v = s_v;
    assign o_rsp.z     = r_zero ? '0 : r_z;

    // checks
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("cordic started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("cordic done without run");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("cordic done longer than a cycle");

endmodule

`default_nettype wire

FILE: hdl/euler_dcm_attitude_converter_unit.sv
// Top level: ZYX Euler angle / direction cosine matrix attitude converter.
//
// Input stream (s_axis): one item is a command in tuser and the row, angle
// and matrix fields in tdata. Output stream (m_axis): one item per input,
// the current roll, pitch, yaw and the nine matrix entries after the command.
// Angle commands rebuild the matrix: three CORDIC sin/cos runs, then the
// multiply-accumulate steps on a shared 23x23 multiplier. Row and column
// writes extract the angles: two CORDIC atan2 runs, a squaring, a square
// root and a third atan2. Unused commands and row index three give a
// result the cycle after acceptance. The CORDIC unit steps one iteration
// a cycle.
// One item is in work at a time: tready is low from acceptance until the
// result is taken. The result holds on tdata while the receiver stalls.
// Reset sets all angles to zero and the matrix to identity.
`timescale 1ns / 1ps
`default_nettype none

module euler_dcm_attitude_converter_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // row_index[1:0], elem_a[17:2], elem_b[33:18], elem_c[49:34],
    // roll_in[65:50], pitch_in[81:66], yaw_in[97:82], zero pad above
    input  wire  [eudc_pkg::IN_DW-1:0]    i_s_axis_tdata,
    // cmd[2:0]
    input  wire  [eudc_pkg::CMD_W-1:0]    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  wire                           i_m_axis_tready,
    // roll_out, pitch_out, yaw_out, m00, m01, m02, m10, m11, m12, m20, m21,
    // m22, 16 bits each from bit 0 up
    output logic [eudc_pkg::OUT_DW-1:0]   o_m_axis_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_TRS, S_TRW, S_MAT, S_EXS, S_EXW, S_SQ, S_SQL, S_SQRT, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        SRC_SR, SRC_CR, SRC_SP, SRC_CP, SRC_SY, SRC_CY, SRC_ONE, SRC_QHI, SRC_PLO
    } t_src;

    typedef enum logic [1:0] {MD_NONE, MD_S0, MD_S20, MD_S21} t_mode;

    typedef struct packed {
        t_src       asel;
        t_src       bsel;
        t_mode      mode;
        logic       neg;
        logic       save;
        logic       wr;
        logic [3:0] widx;
    } t_mstep;

    localparam int RTW = 29;   // square root result width
    localparam int RNW = 57;   // square root radicand width

    // Matrix build program: one multiply per step, accumulate on the next step
    function automatic t_mstep mat_step(input logic [4:0] s);
        t_mstep m;
        case (s)
            5'd0:    m = '{SRC_CP,  SRC_CY,  MD_S20,  1'b0, 1'b0, 1'b0, 4'd0};
            5'd1:    m = '{SRC_CR,  SRC_SY,  MD_S20,  1'b1, 1'b0, 1'b1, 4'd0};
            5'd2:    m = '{SRC_SR,  SRC_SP,  MD_NONE, 1'b0, 1'b0, 1'b0, 4'd0};
            5'd3:    m = '{SRC_QHI, SRC_CY,  MD_S21,  1'b0, 1'b1, 1'b0, 4'd0};
            5'd4:    m = '{SRC_PLO, SRC_CY,  MD_S0,   1'b0, 1'b0, 1'b0, 4'd0};
            5'd5:    m = '{SRC_SR,  SRC_SY,  MD_S20,  1'b0, 1'b0, 1'b1, 4'd1};
            5'd6:    m = '{SRC_CR,  SRC_SP,  MD_NONE, 1'b0, 1'b0, 1'b0, 4'd0};
            5'd7:    m = '{SRC_QHI, SRC_CY,  MD_S21,  1'b0, 1'b1, 1'b0, 4'd0};
            5'd8:    m = '{SRC_PLO, SRC_CY,  MD_S0,   1'b0, 1'b0, 1'b0, 4'd0};
            5'd9:    m = '{SRC_CP,  SRC_SY,  MD_S20,  1'b0, 1'b0, 1'b1, 4'd2};
            5'd10:   m = '{SRC_CR,  SRC_CY,  MD_S20,  1'b0, 1'b0, 1'b1, 4'd3};
            5'd11:   m = '{SRC_SR,  SRC_SP,  MD_NONE, 1'b0, 1'b0, 1'b0, 4'd0};
            5'd12:   m = '{SRC_QHI, SRC_SY,  MD_S21,  1'b0, 1'b1, 1'b0, 4'd0};
            5'd13:   m = '{SRC_PLO, SRC_SY,  MD_S0,   1'b0, 1'b0, 1'b0, 4'd0};
            5'd14:   m = '{SRC_SR,  SRC_CY,  MD_S20,  1'b1, 1'b0, 1'b1, 4'd4};
            5'd15:   m = '{SRC_CR,  SRC_SP,  MD_NONE, 1'b0, 1'b0, 1'b0, 4'd0};
            5'd16:   m = '{SRC_QHI, SRC_SY,  MD_S21,  1'b0, 1'b1, 1'b0, 4'd0};
            5'd17:   m = '{SRC_PLO, SRC_SY,  MD_S0,   1'b0, 1'b0, 1'b0, 4'd0};
            5'd18:   m = '{SRC_SP,  SRC_ONE, MD_S20,  1'b1, 1'b0, 1'b1, 4'd5};
            5'd19:   m = '{SRC_SR,  SRC_CP,  MD_S20,  1'b0, 1'b0, 1'b1, 4'd6};
            5'd20:   m = '{SRC_CR,  SRC_CP,  MD_S20,  1'b0, 1'b0, 1'b1, 4'd7};
            default: m = '{SRC_ONE, SRC_ONE, MD_NONE, 1'b0, 1'b0, 1'b1, 4'd8};
        endcase
        return m;
    endfunction

    localparam logic [4:0] LAST_STEP = 5'd21;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)       r = 16'sh7FFF;
        else if (v < -18'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] to_q13(input logic signed [eudc_pkg::ZW-1:0] z);
        logic signed [eudc_pkg::ZW-1:0] t;
        t = z + 24'sd64;
        return sat16({t[eudc_pkg::ZW-1], t[eudc_pkg::ZW-1:7]});
    endfunction

    t_state                          r_state;
    logic [1:0]                      r_k;
    logic [4:0]                      r_step;
    logic signed [15:0]              r_ang [3];
    logic signed [15:0]              r_mat [9];
    logic signed [eudc_pkg::MW-1:0]  r_sr, r_cr, r_sp, r_cp, r_sy, r_cy;
    logic signed [eudc_pkg::PW-1:0]  r_q;
    logic [20:0]                     r_p;
    t_mode                           r_mode;
    logic                            r_neg;
    logic signed [eudc_pkg::AW-1:0]  r_acc;
    logic [RNW-1:0]                  r_rem;
    logic [RNW:0]                    r_root;
    logic [RNW-1:0]                  r_bit;

    logic                            accept;
    logic [2:0]                      in_cmd;
    logic [1:0]                      in_row;
    logic signed [15:0]              in_el [3];
    logic signed [15:0]              in_ang [3];
    t_mstep                          ms;
    logic signed [eudc_pkg::MW-1:0]  mul_a, mul_b;
    logic signed [eudc_pkg::AW-1:0]  addend;
    logic signed [eudc_pkg::AW-1:0]  n_acc;
    logic signed [eudc_pkg::AW-1:0]  acc_rnd;
    logic signed [15:0]              vsat;
    logic [RTW-1:0]                  nv;
    logic [RNW:0]                    trial;
    eudc_pkg::t_cor_req              cor_req;
    eudc_pkg::t_cor_rsp              cor_rsp;

    // input unpacking
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd    = i_s_axis_tuser;
    assign in_row    = i_s_axis_tdata[1:0];
    assign in_el[0]  = i_s_axis_tdata[17:2];
    assign in_el[1]  = i_s_axis_tdata[33:18];
    assign in_el[2]  = i_s_axis_tdata[49:34];
    assign in_ang[0] = i_s_axis_tdata[65:50];
    assign in_ang[1] = i_s_axis_tdata[81:66];
    assign in_ang[2] = i_s_axis_tdata[97:82];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {r_mat[8], r_mat[7], r_mat[6], r_mat[5], r_mat[4], r_mat[3],
                              r_mat[2], r_mat[1], r_mat[0], r_ang[2], r_ang[1], r_ang[0]};

    // shared multiplier operand select
    function automatic logic signed [eudc_pkg::MW-1:0] src_val(
        input t_src s, input logic signed [eudc_pkg::MW-1:0] sr,
        input logic signed [eudc_pkg::MW-1:0] cr, input logic signed [eudc_pkg::MW-1:0] sp,
        input logic signed [eudc_pkg::MW-1:0] cp, input logic signed [eudc_pkg::MW-1:0] sy,
        input logic signed [eudc_pkg::MW-1:0] cy, input logic signed [eudc_pkg::PW-1:0] q,
        input logic [20:0] p);
        logic signed [eudc_pkg::MW-1:0] v;
        case (s)
            SRC_SR:  v = sr;
            SRC_CR:  v = cr;
            SRC_SP:  v = sp;
            SRC_CP:  v = cp;
            SRC_SY:  v = sy;
            SRC_CY:  v = cy;
            SRC_QHI: v = q[43:21];
            SRC_PLO: v = {2'b00, p};
            default: v = 23'sd1 <<< 20;
        endcase
        return v;
    endfunction

    assign ms   = mat_step(r_step);
    assign vsat = (r_mat[6] > 16'sd16384)  ?  16'sd16384 :
                  (r_mat[6] < -16'sd16384) ? -16'sd16384 : r_mat[6];

    always_comb begin
        if (r_state == S_SQ) begin
            mul_a = {{(eudc_pkg::MW-16){vsat[15]}}, vsat};
            mul_b = {{(eudc_pkg::MW-16){vsat[15]}}, vsat};
        end else begin
            mul_a = src_val(ms.asel, r_sr, r_cr, r_sp, r_cp, r_sy, r_cy, r_q, r_p);
            mul_b = src_val(ms.bsel, r_sr, r_cr, r_sp, r_cp, r_sy, r_cy, r_q, r_p);
        end
    end

    // accumulate the product of the previous step
    always_comb begin
        case (r_mode)
            MD_S0:   addend = eudc_pkg::AW'(r_q);
            MD_S20:  addend = eudc_pkg::AW'(r_q) <<< 20;
            MD_S21:  addend = eudc_pkg::AW'(r_q) <<< 21;
            default: addend = '0;
        endcase
        n_acc   = r_neg ? (r_acc - addend) : (r_acc + addend);
        acc_rnd = (n_acc + (64'sd1 <<< 45)) >>> 46;
    end

    // square root step
    assign nv    = 29'h1000_0000 - r_q[RTW-1:0];
    assign trial = r_root + {1'b0, r_bit};

    // CORDIC requests
    always_comb begin
        cor_req.start = (r_state == S_TRS) || (r_state == S_EXS);
        cor_req.vect  = (r_state == S_EXS);
        cor_req.ang   = r_ang[r_k];
        case (r_k)
            2'd0: begin
                cor_req.x = {{(eudc_pkg::CW-30){r_mat[8][15]}}, r_mat[8], 14'b0};
                cor_req.y = {{(eudc_pkg::CW-30){r_mat[7][15]}}, r_mat[7], 14'b0};
            end
            2'd1: begin
                cor_req.x = {{(eudc_pkg::CW-30){r_mat[0][15]}}, r_mat[0], 14'b0};
                cor_req.y = {{(eudc_pkg::CW-30){r_mat[3][15]}}, r_mat[3], 14'b0};
            end
            default: begin
                cor_req.x = {{(eudc_pkg::CW-RTW){1'b0}}, r_root[RTW-1:0]};
                cor_req.y = {{(eudc_pkg::CW-30){vsat[15]}}, vsat, 14'b0};
            end
        endcase
    end

    eudc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_step  <= '0;
            r_mode  <= MD_NONE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            for (int i = 0; i < 3; i++) r_ang[i] <= '0;
            for (int e = 0; e < 9; e++) r_mat[e] <= (e % 4 == 0) ? 16'sd16384 : 16'sd0;
        end else begin
            r_q    <= mul_a * mul_b;
            r_mode <= MD_NONE;
            r_neg  <= 1'b0;
            r_acc  <= '0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_k <= '0;
                        if ((in_cmd == eudc_pkg::CMD_ROW || in_cmd == eudc_pkg::CMD_COL)
                            && in_row != 2'(eudc_pkg::NROW)) begin
                            for (int e = 0; e < 9; e++) begin
                                if (in_cmd == eudc_pkg::CMD_ROW && in_row == 2'(e / 3))
                                    r_mat[e] <= in_el[e % 3];
                                if (in_cmd == eudc_pkg::CMD_COL && in_row == 2'(e % 3))
                                    r_mat[e] <= in_el[e / 3];
                            end
                            r_state <= S_EXS;
                        end else if (in_cmd == eudc_pkg::CMD_ALL ||
                                     in_cmd == eudc_pkg::CMD_ROLL ||
                                     in_cmd == eudc_pkg::CMD_PITCH ||
                                     in_cmd == eudc_pkg::CMD_YAW) begin
                            if (in_cmd == eudc_pkg::CMD_ALL || in_cmd == eudc_pkg::CMD_ROLL)
                                r_ang[0] <= in_ang[0];
                            if (in_cmd == eudc_pkg::CMD_ALL || in_cmd == eudc_pkg::CMD_PITCH)
                                r_ang[1] <= in_ang[1];
                            if (in_cmd == eudc_pkg::CMD_ALL || in_cmd == eudc_pkg::CMD_YAW)
                                r_ang[2] <= in_ang[2];
                            r_state <= S_TRS;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                // sin/cos of each angle in turn
                S_TRS: r_state <= S_TRW;
                S_TRW: begin
                    if (cor_rsp.done) begin
                        case (r_k)
                            2'd0: begin r_sr <= cor_rsp.sin_v; r_cr <= cor_rsp.cos_v; end
                            2'd1: begin r_sp <= cor_rsp.sin_v; r_cp <= cor_rsp.cos_v; end
                            default: begin r_sy <= cor_rsp.sin_v; r_cy <= cor_rsp.cos_v; end
                        endcase
                        if (r_k == 2'd2) begin
                            r_step  <= '0;
                            r_state <= S_MAT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_TRS;
                        end
                    end
                end
                // matrix terms on the shared multiplier
                S_MAT: begin
                    r_mode <= ms.mode;
                    r_neg  <= ms.neg;
                    if (ms.save) r_p <= r_q[20:0];
                    if (ms.wr) begin
                        r_mat[ms.widx] <= sat16(acc_rnd[17:0]);
                        r_acc          <= '0;
                    end else begin
                        r_acc <= n_acc;
                    end
                    if (r_step == LAST_STEP) r_state <= S_OUT;
                    r_step <= r_step + 1'b1;
                end
                // atan2 runs: roll, yaw, then pitch through asin
                S_EXS: r_state <= S_EXW;
                S_EXW: begin
                    if (cor_rsp.done) begin
                        case (r_k)
                            2'd0: begin
                                r_ang[0] <= to_q13(cor_rsp.z);
                                r_k      <= 2'd1;
                                r_state  <= S_EXS;
                            end
                            2'd1: begin
                                r_ang[2] <= to_q13(cor_rsp.z);
                                r_state  <= S_SQ;
                            end
                            default: begin
                                r_ang[1] <= to_q13(-cor_rsp.z);
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SQ: r_state <= S_SQL;
                S_SQL: begin
                    r_rem   <= {nv, 28'b0};
                    r_root  <= '0;
                    r_bit   <= RNW'(1) << (RNW - 1);
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_k     <= 2'd2;
                        r_state <= S_EXS;
                    end else begin
                        if ({1'b0, r_rem} >= trial) begin
                            r_rem  <= r_rem - trial[RNW-1:0];
                            r_root <= (r_root >> 1) + {1'b0, r_bit};
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_OUT: begin
                    if (i_m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input taken while a result waits");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer idle right after accept");
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_rsp.done |-> (r_state == S_TRW || r_state == S_EXW))
        else $error("cordic result with no consumer");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the Euler angle / direction cosine matrix converter.
`timescale 1ns / 1ps

// Attitude predictor and queue of expected result items
class attitude_scoreboard;
    localparam longint PI_Q20      = 64'sd3294199;
    localparam longint HALF_PI_Q20 = 64'sd1647099;
    localparam longint K30         = 64'sd652032874;
    localparam longint ONE_Q20     = 64'sd1048576;

    logic signed [15:0] ang [3];
    logic signed [15:0] dcm [9];
    logic [191:0]       pending [$];
    int                 errors;

    function new();
        errors = 0;
        for (int i = 0; i < 3; i++) ang[i] = '0;
        for (int i = 0; i < 9; i++) dcm[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
    endfunction

    function longint atan_step(int i);
        longint t [20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                           4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    function longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function void sincos(logic signed [15:0] a, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     flip;
        z = longint'(a) * 128;
        x = K30;
        y = 0;
        flip = 0;
        if (z > HALF_PI_Q20) begin
            z -= PI_Q20;
            flip = 1;
        end else if (z < -HALF_PI_Q20) begin
            z += PI_Q20;
            flip = 1;
        end
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    function longint atan2_q20(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q20 : -PI_Q20;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function longint unsigned isqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function longint asin_q20(longint v);
        longint unsigned r;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        r = longint'(268435456 - v * v) << 28;
        return atan2_q20(v * 16384, longint'(isqrt(r)));
    endfunction

    function logic [15:0] q13(longint z);
        return 16'(sat16((z + 64) >>> 7));
    endfunction

    function logic [15:0] q14(longint v);
        return 16'(sat16((v + (64'sd1 << 45)) >>> 46));
    endfunction

    function void rebuild();
        longint sp, cp, st, ct, ss, cs;
        sincos(ang[0], sp, cp);
        sincos(ang[1], st, ct);
        sincos(ang[2], ss, cs);
        dcm[0] = q14(ct * cs * ONE_Q20);
        dcm[1] = q14(-cp * ss * ONE_Q20 + sp * st * cs);
        dcm[2] = q14(sp * ss * ONE_Q20 + cp * st * cs);
        dcm[3] = q14(ct * ss * ONE_Q20);
        dcm[4] = q14(cp * cs * ONE_Q20 + sp * st * ss);
        dcm[5] = q14(-sp * cs * ONE_Q20 + cp * st * ss);
        dcm[6] = q14(-st * ONE_Q20 * ONE_Q20);
        dcm[7] = q14(sp * ct * ONE_Q20);
        dcm[8] = q14(cp * ct * ONE_Q20);
    endfunction

    function void extract();
        ang[0] = q13(atan2_q20(longint'(dcm[7]) * 16384, longint'(dcm[8]) * 16384));
        ang[1] = q13(-asin_q20(longint'(dcm[6])));
        ang[2] = q13(atan2_q20(longint'(dcm[3]) * 16384, longint'(dcm[0]) * 16384));
    endfunction

    // Apply one accepted input item and queue the resulting attitude
    function void note_input(logic [2:0] cmd, logic [103:0] d);
        logic [1:0]   r;
        logic [191:0] res;
        r = d[1:0];
        if ((cmd == eudc_pkg::CMD_ROW || cmd == eudc_pkg::CMD_COL) && r < 3) begin
            for (int k = 0; k < 3; k++) begin
                if (cmd == eudc_pkg::CMD_ROW) dcm[r * 3 + k] = d[2 + 16 * k +: 16];
                else dcm[k * 3 + r] = d[2 + 16 * k +: 16];
            end
            extract();
        end else if (cmd >= eudc_pkg::CMD_ALL && cmd <= eudc_pkg::CMD_YAW) begin
            if (cmd == eudc_pkg::CMD_ALL || cmd == eudc_pkg::CMD_ROLL) ang[0] = d[65:50];
            if (cmd == eudc_pkg::CMD_ALL || cmd == eudc_pkg::CMD_PITCH) ang[1] = d[81:66];
            if (cmd == eudc_pkg::CMD_ALL || cmd == eudc_pkg::CMD_YAW) ang[2] = d[97:82];
            rebuild();
        end
        for (int i = 0; i < 3; i++) res[16 * i +: 16] = ang[i];
        for (int i = 0; i < 9; i++) res[48 + 16 * i +: 16] = dcm[i];
        pending.push_back(res);
    endfunction

    // Compare one result item against the oldest expectation, field by field
    function void check_result(logic [191:0] got);
        logic [191:0] want;
        string        names [12] = '{"roll", "pitch", "yaw", "m00", "m01", "m02",
                                     "m10", "m11", "m12", "m20", "m21", "m22"};
        if (pending.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        for (int i = 0; i < 12; i++) begin
            if (got[16 * i +: 16] !== want[16 * i +: 16]) begin
                $display("%0t: %s expected %0d actual %0d", $time, names[i],
                         $signed(want[16 * i +: 16]), $signed(got[16 * i +: 16]));
                errors++;
            end
        end
    endfunction
endclass

module tb_top;

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        s_valid = 0;
    logic                        s_ready;
    logic [eudc_pkg::IN_DW-1:0]  s_data = '0;
    logic [eudc_pkg::CMD_W-1:0]  s_user = '0;
    logic                        m_valid;
    logic                        m_ready = 0;
    logic [eudc_pkg::OUT_DW-1:0] m_data;

    attitude_scoreboard sb = new();
    bit  quiet = 0;      // no idling on either side
    int  hold_off = 0;   // receiver stall cycles still to serve
    bit  sent_all = 0;
    int  idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    euler_dcm_attitude_converter_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data)
    );

    // Monitor: note accepted inputs, check accepted results, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready) sb.note_input(s_user, s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver: random stalls, long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_ready <= 0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 18);
        end
    end

    // Offer one item; valid stays up afterwards unless an idle gap follows
    task automatic send_item(logic [2:0] cmd, logic [1:0] r, logic [15:0] ea,
                             logic [15:0] eb, logic [15:0] ec, logic [15:0] ro,
                             logic [15:0] pi, logic [15:0] ya);
        while (!quiet && $urandom_range(99) < 18) begin
            s_valid <= 0;
            @(negedge i_clk);
        end
        s_valid <= 1;
        s_user  <= cmd;
        s_data  <= {6'd0, ya, pi, ro, ec, eb, ea, r};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(25736)) - 12868);  // within +-pi/2
            2: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(32768)) - 16384);   // within +-1
            2: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(600)) - 300);
        endcase
    endfunction

    // Stop offering and wait for every expected result
    task automatic wait_drained();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [2:0]  cmd;
        logic [15:0] e [3];
        int          n;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: every command, field extremes, special cases
        send_item(eudc_pkg::CMD_ALL, 0, 0, 0, 0, 16'd0, 16'd0, 16'd0);
        send_item(eudc_pkg::CMD_ALL, 0, 0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);  // beyond +-pi
        send_item(eudc_pkg::CMD_ROLL, 0, 0, 0, 0, 16'd6434, 0, 0);
        send_item(eudc_pkg::CMD_PITCH, 0, 0, 0, 0, 0, 16'hf3de, 0);
        send_item(eudc_pkg::CMD_YAW, 0, 0, 0, 0, 0, 0, 16'h8000);
        send_item(eudc_pkg::CMD_ALL, 0, 0, 0, 0, 16'd4000, 16'd12868, 16'hc000);  // pitch at pi/2
        send_item(eudc_pkg::CMD_ROW, 0, 16'd16384, 0, 0, 0, 0, 0);
        send_item(eudc_pkg::CMD_ROW, 2, 0, 0, 0, 0, 0, 0);                        // zero vector
        send_item(eudc_pkg::CMD_ROW, 2, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0);  // asin saturates
        send_item(eudc_pkg::CMD_COL, 0, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
        send_item(eudc_pkg::CMD_COL, 1, 16'hffff, 16'h0001, 16'h8000, 0, 0, 0);
        send_item(eudc_pkg::CMD_ROW, 1, 16'h8000, 16'h7fff, 0, 0, 0, 0);
        send_item(eudc_pkg::CMD_ROW, 3, 16'h1234, 16'h5678, 16'h9abc, 0, 0, 0);  // ignored row
        send_item(eudc_pkg::CMD_COL, 3, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0);
        send_item(3'd6, 2, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_item(3'd7, 1, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);

        // Receiver holds off while the sender keeps offering items
        hold_off = 400;
        for (int i = 0; i < 4; i++) send_item(eudc_pkg::CMD_ALL, 0, 0, 0, 0, rand_angle(),
                                              rand_angle(), rand_angle());
        wait_drained();

        // Random items; a stretch without idling in the middle
        for (int i = 0; i < 1880; i++) begin
            quiet = (i >= 800 && i < 1000);
            n = $urandom_range(99);
            if (n < 40) cmd = 3'($urandom_range(1));
            else if (n < 94) cmd = 3'($urandom_range(5, 2));
            else cmd = 3'($urandom_range(7, 6));
            for (int k = 0; k < 3; k++) e[k] = rand_elem();
            send_item(cmd, ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2)),
                      e[0], e[1], e[2], rand_angle(), rand_angle(), rand_angle());
            if (i == 1500) wait_drained();
        end
        quiet = 0;

        // Drain and let the block settle
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0 && !m_valid) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

FILE: euler_dcm_attitude_converter_unit.f
hdl/eudc_pkg.sv
hdl/eudc_cordic.sv
hdl/euler_dcm_attitude_converter_unit.sv
dv/tb_top.sv
